FILE: sv/sbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_IN_W  = 10;
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int DATA_W      = 32;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    typedef struct packed {
        logic wr;
        logic load;
        logic step;
    } sbs_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } sbs_status_t;

endpackage

FILE: sv/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Joins sbs_ctrl and sbs_dp; depends on sbs_pkg.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A write request
// stores one entry and gives no result. A search request probes the table
// once per cycle, one read of the table memory each, until the span of the
// clamped table size is used up; the result is shown on found and position
// with done high for exactly one cycle after the last probe.
// An empty table gives its result in the cycle after the request.
// The receiver cannot stall: capture found and position while done is high.
// A new request may be given in the cycle that done is high.

module sorted_table_binary_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic        [sbs_pkg::ENTRY_IN_W-1:0] entry_index,
    input  logic signed [sbs_pkg::DATA_W-1:0]     value,
    output logic                                done,
    output logic                                found,
    output logic        [sbs_pkg::POS_W-1:0]      position,
    input  logic                                cfg_we,
    input  logic        [sbs_pkg::SIZE_W-1:0]     cfg_wdata
);

    sbs_pkg::sbs_cmd_t    cmd;
    sbs_pkg::sbs_status_t status;

    sbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    sbs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_index (entry_index),
        .value       (value),
        .found       (found),
        .position    (position)
    );

endmodule

FILE: sv/sbs_ctrl.sv
// Controller state machine for the binary search block.
// Depends on sbs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module sbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                opcode,
    input  sbs_pkg::sbs_status_t status,
    output sbs_pkg::sbs_cmd_t   cmd,
    output logic                busy,
    output logic                done
);

    sbs_pkg::state_t state_reg;
    sbs_pkg::state_t state_next;
    logic            accept;

    assign busy   = (state_reg == sbs_pkg::ST_SEARCH);
    assign done   = (state_reg == sbs_pkg::ST_RESULT);
    assign accept = start && !busy;

    assign cmd.wr   = accept && (opcode == sbs_pkg::OP_WRITE);
    assign cmd.load = accept && (opcode == sbs_pkg::OP_SEARCH);
    assign cmd.step = busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbs_pkg::ST_IDLE,
            sbs_pkg::ST_RESULT:
            begin
                if (cmd.load)
                begin
                    state_next = status.empty ? sbs_pkg::ST_RESULT : sbs_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = sbs_pkg::ST_IDLE;
                end
            end
            sbs_pkg::ST_SEARCH:
            begin
                if (status.last)
                begin
                    state_next = sbs_pkg::ST_RESULT;
                end
            end
            default:
            begin
                state_next = sbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/sbs_dp.sv
// Datapath of the binary search block: table memory, span bounds, probe
// compare and result registers. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbs_pkg::sbs_cmd_t                   cmd,
    output sbs_pkg::sbs_status_t                status,
    input  logic                                cfg_we,
    input  logic        [sbs_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic        [sbs_pkg::ENTRY_IN_W-1:0] entry_index,
    input  logic signed [sbs_pkg::DATA_W-1:0]     value,
    output logic                                found,
    output logic        [sbs_pkg::POS_W-1:0]      position
);

    localparam int CNT_W = sbs_pkg::CNT_W;
    localparam int IDX_W = sbs_pkg::IDX_W;

    logic signed [sbs_pkg::DATA_W-1:0] mem [sbs_pkg::TABLE_DEPTH];
    logic signed [sbs_pkg::DATA_W-1:0] rdata_reg;
    logic signed [sbs_pkg::DATA_W-1:0] key_reg;

    logic [sbs_pkg::SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]           n_sat;
    logic [CNT_W-1:0]           lo_reg, lo_next;
    logic [CNT_W-1:0]           hip1_reg, hip1_next;
    logic [IDX_W-1:0]           mid_reg, mid_init, mid_step, raddr;
    logic [CNT_W:0]             mid_sum;
    logic                       hit_reg, hit_next;
    logic [IDX_W-1:0]           hit_pos_reg, hit_pos_next;
    logic                       found_reg;
    logic [sbs_pkg::POS_W-1:0]  pos_reg;
    logic                       wr_ok;
    logic                       below;

    // Clamp the configured size to the table depth.
    assign n_sat = (size_reg > sbs_pkg::SIZE_W'(sbs_pkg::TABLE_DEPTH))
                   ? CNT_W'(sbs_pkg::TABLE_DEPTH) : CNT_W'(size_reg);
    assign status.empty = (n_sat == '0);
    assign mid_init = IDX_W'((n_sat - CNT_W'(1)) >> 1);

    assign below        = (rdata_reg < key_reg);
    assign hit_next     = hit_reg || (rdata_reg == key_reg);
    assign hit_pos_next = (rdata_reg == key_reg) ? mid_reg : hit_pos_reg;
    assign lo_next      = below ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign hip1_next    = below ? hip1_reg : CNT_W'(mid_reg);
    assign status.last  = (lo_next >= hip1_next);

    assign mid_sum  = {1'b0, lo_next} + {1'b0, hip1_next} - (CNT_W + 1)'(1);
    assign mid_step = IDX_W'(mid_sum >> 1);
    assign raddr    = cmd.load ? mid_init : mid_step;

    assign wr_ok = (32'(entry_index) < 32'(sbs_pkg::TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok)
        begin
            mem[IDX_W'(entry_index)] <= value;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= '0;
            lo_reg      <= '0;
            hip1_reg    <= '0;
            mid_reg     <= '0;
            key_reg     <= '0;
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
            found_reg   <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                lo_reg      <= '0;
                hip1_reg    <= n_sat;
                mid_reg     <= mid_init;
                key_reg     <= value;
                hit_reg     <= 1'b0;
                hit_pos_reg <= '0;
                if (status.empty)
                begin
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                end
            end
            else if (cmd.step)
            begin
                lo_reg      <= lo_next;
                hip1_reg    <= hip1_next;
                mid_reg     <= mid_step;
                hit_reg     <= hit_next;
                hit_pos_reg <= hit_pos_next;
                if (status.last)
                begin
                    found_reg <= hit_next;
                    pos_reg   <= hit_next ? sbs_pkg::POS_W'(hit_pos_next) : '0;
                end
            end
        end
    end

    assign found    = found_reg;
    assign position = pos_reg;

endmodule

FILE: sv/sbs_chk.sv
// Port-level checker for the sorted table binary search block, bound to
// the top level. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           opcode,
    input logic                           done,
    input logic                           found,
    input logic [sbs_pkg::POS_W-1:0]      position
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("nonzero position on a miss");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == sbs_pkg::OP_WRITE)) |=> (!busy && !done))
        else $error("write request started a search");

    a_search_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == sbs_pkg::OP_SEARCH)) |=> (busy || done))
        else $error("search request dropped");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && (opcode == sbs_pkg::OP_SEARCH))))
        else $error("result without a search");

endmodule

bind sorted_table_binary_search sbs_chk u_sbs_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .done     (done),
    .found    (found),
    .position (position)
);

FILE: tb/tb_sorted_table_binary_search.sv
// Testbench for sorted_table_binary_search: directed table, full table fill, random phases.
// Predicts search results from its table copy unless a directed row gives them; depends on sbs_pkg and the block.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int NUM_DIR        = 25;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam logic signed [sbs_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [sbs_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                      found;
        logic [sbs_pkg::POS_W-1:0] position;
    } search_res_t;

    typedef enum logic {
        DIR_REQ = 1'b0,
        DIR_CFG = 1'b1
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t                         kind;
        sbs_pkg::opcode_t                  op;
        logic [sbs_pkg::ENTRY_IN_W-1:0]    idx;
        logic signed [sbs_pkg::DATA_W-1:0] val;
        logic                              typed;
        search_res_t                       want;
    } dir_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              opcode = 1'b0;
    logic [sbs_pkg::ENTRY_IN_W-1:0]    entry_index = '0;
    logic signed [sbs_pkg::DATA_W-1:0] value = '0;
    logic                              done;
    logic                              found;
    logic [sbs_pkg::POS_W-1:0]         position;
    logic                              cfg_we = 1'b0;
    logic [sbs_pkg::SIZE_W-1:0]        cfg_wdata = '0;

    logic signed [sbs_pkg::DATA_W-1:0] table_copy [sbs_pkg::TABLE_DEPTH];
    logic [sbs_pkg::SIZE_W-1:0]        search_size = '0;
    search_res_t                       pending_results [$];
    int                                err_count = 0;
    int                                stall_cycles = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    32'sd0,  1'b1, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd0,    KEY_MIN, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd1,    -32'sd5, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd2,    -32'sd5, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd3,    32'sd0,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd4,    32'sd7,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd5,    32'sd7,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd6,    32'sd7,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd7,    KEY_MAX, 1'b0, '{1'b0, 10'd0}},
        '{DIR_CFG, sbs_pkg::OP_WRITE,  10'd0,    32'sd8,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd1023, KEY_MIN, 1'b1, '{1'b1, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    KEY_MAX, 1'b1, '{1'b1, 10'd7}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd5,    32'sd7,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    -32'sd5, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    32'sd3,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    32'sh8000_0001, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_WRITE,  10'd1023, -32'sd1, 1'b0, '{1'b0, 10'd0}},
        '{DIR_CFG, sbs_pkg::OP_WRITE,  10'd0,    32'sd0,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    KEY_MAX, 1'b1, '{1'b0, 10'd0}},
        '{DIR_CFG, sbs_pkg::OP_WRITE,  10'd0,    32'sd1,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    KEY_MIN, 1'b1, '{1'b1, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    32'sd0,  1'b1, '{1'b0, 10'd0}},
        '{DIR_CFG, sbs_pkg::OP_WRITE,  10'd0,    32'sd7,  1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    KEY_MAX, 1'b0, '{1'b0, 10'd0}},
        '{DIR_REQ, sbs_pkg::OP_SEARCH, 10'd0,    32'sd0,  1'b0, '{1'b0, 10'd0}}
    };

    sorted_table_binary_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .entry_index (entry_index),
        .value       (value),
        .done        (done),
        .found       (found),
        .position    (position),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic search_res_t predict_search(logic signed [sbs_pkg::DATA_W-1:0] key);
        int          lo;
        int          hi;
        int          mid;
        int          hit;
        int          span;
        search_res_t res;
        span = (search_size > sbs_pkg::TABLE_DEPTH) ? sbs_pkg::TABLE_DEPTH : int'(search_size);
        lo   = 0;
        hi   = span - 1;
        hit  = -1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_copy[mid] == key)
                hit = mid;
            if (table_copy[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        res.found    = (hit >= 0);
        res.position = (hit >= 0) ? hit[sbs_pkg::POS_W-1:0] : '0;
        return res;
    endfunction

    task automatic issue(sbs_pkg::opcode_t op, logic [sbs_pkg::ENTRY_IN_W-1:0] idx,
                         logic signed [sbs_pkg::DATA_W-1:0] val, logic typed,
                         search_res_t typed_want, int idle_pct);
        begin
            if (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < idle_pct);
            end
            start       <= 1'b1;
            opcode      <= op;
            entry_index <= idx;
            value       <= val;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            if (op == sbs_pkg::OP_WRITE)
                table_copy[idx] = val;
            else
                pending_results.push_back(typed ? typed_want : predict_search(val));
        end
    endtask

    // hold requests until every search result is back
    task automatic drain_results();
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
        end
    endtask

    task automatic load_size(logic [sbs_pkg::SIZE_W-1:0] sz);
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= sz;
            @(posedge clk);
            cfg_we      <= 1'b0;
            search_size  = sz;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        search_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: found %0d position %0d", found, position);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    err_count++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, position);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sorted_table_binary_search verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int                                idle_by_phase [4];
        logic [sbs_pkg::SIZE_W-1:0]        phase_size [NUM_PHASES];
        int                                fill_order [sbs_pkg::TABLE_DEPTH];
        logic signed [sbs_pkg::DATA_W-1:0] fill_vals [sbs_pkg::TABLE_DEPTH];
        longint                            acc;
        longint                            lo_v;
        longint                            hi_v;
        int                                j;
        int                                tmp;
        int                                r;
        int                                idle;
        logic [sbs_pkg::ENTRY_IN_W-1:0]    idx;
        logic signed [sbs_pkg::DATA_W-1:0] key;

        idle_by_phase = '{0, 75, 0, 13};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == DIR_CFG)
                load_size(dir_rows[i].val[sbs_pkg::SIZE_W-1:0]);
            else
                issue(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].want, 0);
        end

        // fill the whole table in ascending order, written in shuffled order
        acc = -64'sd2147483648;
        for (int i = 0; i < sbs_pkg::TABLE_DEPTH; i++)
        begin
            fill_vals[i]  = acc[sbs_pkg::DATA_W-1:0];
            fill_order[i] = i;
            if ($urandom_range(3) != 0)
                acc = acc + $urandom_range(1, 1 << 22);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
        end
        fill_vals[sbs_pkg::TABLE_DEPTH-1] = KEY_MAX;
        for (int i = sbs_pkg::TABLE_DEPTH - 1; i > 0; i--)
        begin
            j             = $urandom_range(i);
            tmp           = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
        end
        for (int i = 0; i < sbs_pkg::TABLE_DEPTH; i++)
            issue(sbs_pkg::OP_WRITE, fill_order[i][sbs_pkg::ENTRY_IN_W-1:0],
                  fill_vals[fill_order[i]], 1'b0, '0, 13);

        phase_size = '{11'd1024, 11'd2047, 11'd0, 11'd1, 11'd2, 11'd1023,
                       11'd0, 11'd0};
        phase_size[6] = sbs_pkg::SIZE_W'($urandom_range(3, 1022));
        phase_size[7] = sbs_pkg::SIZE_W'($urandom_range(2047));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_size(phase_size[p]);
            idle = idle_by_phase[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(99) == 0)
                    drain_results();
                r   = $urandom_range(99);
                idx = sbs_pkg::ENTRY_IN_W'($urandom_range(sbs_pkg::TABLE_DEPTH - 1));
                if (r < 75)
                begin
                    key = table_copy[$urandom_range(sbs_pkg::TABLE_DEPTH - 1)];
                    if (r >= 60)
                        key = $urandom;
                    else if (r >= 45)
                        key = $urandom_range(1) ? key + 1 : key - 1;
                    issue(sbs_pkg::OP_SEARCH, idx, key, 1'b0, '0, idle);
                end
                else
                begin
                    lo_v = (idx == 0) ? -64'sd2147483648 : longint'(table_copy[idx - 1]);
                    hi_v = (idx == sbs_pkg::TABLE_DEPTH - 1) ? 64'sd2147483647
                                                             : longint'(table_copy[idx + 1]);
                    r = $urandom_range(99);
                    if (lo_v > hi_v || r >= 90)
                        key = $urandom;
                    else if (r < 70)
                        key = sbs_pkg::DATA_W'(lo_v + (longint'($urandom) % (hi_v - lo_v + 1)));
                    else
                        key = sbs_pkg::DATA_W'(lo_v);
                    issue(sbs_pkg::OP_WRITE, idx, key, 1'b0, '0, idle);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("sorted_table_binary_search verification clean");
        else
            $display("sorted_table_binary_search verification failed");
        $finish;
    end

endmodule
